// ===== rtl/core/task_dependency_graph_builder_unit_assert.svh =====
// assertion macros for the task dependency graph builder
`ifndef TASK_DEPENDENCY_GRAPH_BUILDER_UNIT_ASSERT_SVH
`define TASK_DEPENDENCY_GRAPH_BUILDER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define TDG_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TDG_ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) else $error(msg);
`else
`define TDG_ASSERT(label, clk, rst_n, prop, msg)
`define TDG_ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg)
`endif
`endif

// ===== rtl/core/tdgb_pkg.sv =====
// shared types and constants of the task dependency graph builder
`default_nettype none
package tdgb_pkg;
	localparam int unsigned RES_ID_W = 16;
	localparam int unsigned OUT_TASKS = 16;
	localparam int unsigned OUT_IDX_W = 4;

	typedef struct packed {
		logic [RES_ID_W-1:0] resource_id;
		logic                rd_only;
		logic                entry_valid;
		logic                end_of_task;
		logic                end_of_set;
	} tdgb_req_t;

	typedef struct packed {
		logic [OUT_IDX_W-1:0] task_index;
		logic [OUT_TASKS-1:0] dependency_mask;
		logic                 last;
		logic                 overflow;
	} tdgb_rsp_t;
endpackage
`default_nettype wire

// ===== rtl/core/task_dependency_graph_builder_unit.sv =====
// task dependency graph builder: loads task access lists, builds and prunes the hazard graph
// A set is loaded one request per cycle; each access entry that fits lands in the entry
// memory. After the request that closes the last task the block stops taking requests,
// compares each entry of the later task of every task pair with the entries of the earlier
// task, up to the first match, through the single entry-memory read port, then prunes the
// adjacency rows (one (i,j,k) step per cycle), and sends one response per task, at most
// sixteen. Loading starts again once the last response is taken and the block has returned
// to its load state.
`default_nettype none
module task_dependency_graph_builder_unit
	import tdgb_pkg::*;
#(
	parameter int unsigned MAX_TASKS   = 16,
	parameter int unsigned MAX_ENTRIES = 8,
	parameter int unsigned ID_BITS     = 16
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire tdgb_req_t in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output tdgb_rsp_t      out_data
);
`include "task_dependency_graph_builder_unit_assert.svh"

	localparam int unsigned TW   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int unsigned EW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int unsigned CW   = $clog2(MAX_TASKS + 1);
	localparam int unsigned ECW  = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned AW   = TW + EW;
	localparam int unsigned NOUT = (MAX_TASKS < OUT_TASKS) ? MAX_TASKS : OUT_TASKS;

	localparam logic [2:0] ST_LOAD  = 3'd0;
	localparam logic [2:0] ST_READA = 3'd1;
	localparam logic [2:0] ST_CMP   = 3'd2;
	localparam logic [2:0] ST_PRUNE = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	logic [2:0] state_q;

	// entry memory
	logic [ID_BITS:0] mem [2**AW];
	logic [ID_BITS:0] rd_q;
	logic             we;
	logic [AW-1:0]    wa, ra;
	logic [ID_BITS:0] wd;

	logic [ECW-1:0] cnt_q [MAX_TASKS];
	logic [CW-1:0]  tcount_q;
	logic           ovf_q;
	logic [MAX_TASKS-1:0] adj_q [MAX_TASKS];

	// compare walk: task i entry a vs task j entries b
	logic [CW-1:0]    i_q, k_q;
	logic [TW-1:0]    j_q;
	logic [EW-1:0]    a_q, b_q;
	logic [ID_BITS:0] a_ent_q;
	logic             rd_is_b_q;
	logic             found_q;
	logic             hz_q;
	logic [CW-1:0]    emit_q;
	logic [CW-1:0]    nout;

	logic [ID_BITS-1:0] id_in;
	logic [TW-1:0]      cur_t;
	logic [TW-1:0]      i_t, k_t;
	logic               tfull;

	assign id_in = ID_BITS'(in_data.resource_id);
	assign tfull = (tcount_q == CW'(MAX_TASKS));
	assign cur_t = tcount_q[TW-1:0];
	assign i_t = i_q[TW-1:0];
	assign k_t = k_q[TW-1:0];
	assign in_ready = (state_q == ST_LOAD);
	assign nout = (tcount_q < CW'(NOUT)) ? tcount_q : CW'(NOUT);

	always_comb begin
		we = 1'b0;
		wa = {cur_t, cnt_q[cur_t][EW-1:0]};
		wd = {id_in, in_data.rd_only};
		ra = {i_t, a_q};
		if (state_q == ST_LOAD && in_valid && in_data.entry_valid && !tfull &&
			cnt_q[cur_t] < ECW'(MAX_ENTRIES))
			we = 1'b1;
		// address one entry ahead so the data lines up with b
		if (state_q == ST_CMP)
			ra = rd_is_b_q ? {j_q, b_q + EW'(1)} : {j_q, EW'(0)};
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		rd_q <= mem[ra];
	end

	// b is the last entry of task j being compared
	logic b_last, a_last, eq, hit;
	logic [ECW-1:0] cj, ci;
	assign cj = cnt_q[j_q];
	assign ci = cnt_q[i_t];
	assign b_last = (ECW'(b_q) + ECW'(1) >= cj);
	assign a_last = (ECW'(a_q) + ECW'(1) >= ci);
	assign eq = (rd_q[ID_BITS:1] == a_ent_q[ID_BITS:1]);
	// read entry: needs first match to be a write; write entry: any touch
	assign hit = eq && (!a_ent_q[0] || !rd_q[0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			tcount_q  <= '0;
			ovf_q     <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
			k_q       <= '0;
			a_q       <= '0;
			b_q       <= '0;
			a_ent_q   <= '0;
			found_q   <= 1'b0;
			hz_q      <= 1'b0;
			rd_is_b_q <= 1'b0;
			emit_q    <= '0;
			for (int t = 0; t < MAX_TASKS; t++) begin
				cnt_q[t] <= '0;
				adj_q[t] <= '0;
			end
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_valid) begin
						if (in_data.entry_valid) begin
							if (tfull || cnt_q[cur_t] >= ECW'(MAX_ENTRIES))
								ovf_q <= 1'b1;
							else
								cnt_q[cur_t] <= cnt_q[cur_t] + ECW'(1);
						end
						if (in_data.end_of_task || in_data.end_of_set) begin
							if (tfull)
								ovf_q <= 1'b1;
							else
								tcount_q <= tcount_q + CW'(1);
						end
						if (in_data.end_of_set) begin
							state_q <= ST_READA;
							i_q     <= '0;
							j_q     <= '0;
							a_q     <= '0;
							b_q     <= '0;
							hz_q    <= 1'b0;
							for (int t = 0; t < MAX_TASKS; t++)
								adj_q[t] <= '0;
						end
					end
				end
				ST_READA: begin
					// pair (i,j) with j<i; a indexes entries of i
					if (i_q >= tcount_q) begin
						state_q <= ST_PRUNE;
						i_q <= '0;
						j_q <= '0;
						k_q <= CW'(1);
					end else if (CW'(j_q) >= i_q || ci == '0 || hz_q) begin
						if (hz_q)
							adj_q[i_t][j_q] <= 1'b1;
						hz_q <= 1'b0;
						a_q  <= '0;
						if (CW'(j_q) >= i_q) begin
							j_q <= '0;
							i_q <= i_q + CW'(1);
						end else begin
							j_q <= j_q + TW'(1);
						end
					end else if (cj == '0) begin
						j_q <= j_q + TW'(1);
						a_q <= '0;
					end else begin
						// address {i,a} presented this cycle
						state_q   <= ST_CMP;
						rd_is_b_q <= 1'b0;
						b_q       <= '0;
						found_q   <= 1'b0;
					end
				end
				ST_CMP: begin
					if (!rd_is_b_q) begin
						a_ent_q   <= rd_q;
						rd_is_b_q <= 1'b1;
					end else begin
						if (eq && !found_q) begin
							found_q <= 1'b1;
							if (hit)
								hz_q <= 1'b1;
						end
						if (b_last || (eq && !found_q)) begin
							state_q <= ST_READA;
							if (a_last) begin
								a_q <= '0;
								if (!(eq && !found_q && hit) && !hz_q) begin
									// done with pair without hazard: advance
									j_q <= j_q + TW'(1);
								end
							end else begin
								a_q <= a_q + EW'(1);
							end
						end else begin
							b_q <= b_q + EW'(1);
						end
					end
				end
				ST_PRUNE: begin
					// step (i,j,k): k>i, edge i->j and k->i clears k->j
					if (i_q >= tcount_q) begin
						state_q <= ST_EMIT;
						emit_q  <= '0;
					end else if (CW'(j_q) >= i_q || k_q >= tcount_q || !adj_q[i_t][j_q]) begin
						if (CW'(j_q) >= i_q || i_q + CW'(1) >= tcount_q) begin
							j_q <= '0;
							i_q <= i_q + CW'(1);
							k_q <= i_q + CW'(2);
						end else begin
							j_q <= j_q + TW'(1);
							k_q <= i_q + CW'(1);
						end
					end else begin
						if (adj_q[k_t][i_t])
							adj_q[k_t][j_q] <= 1'b0;
						k_q <= k_q + CW'(1);
					end
				end
				ST_EMIT: begin
					if (emit_q >= nout) begin
						state_q  <= ST_LOAD;
						tcount_q <= '0;
						ovf_q    <= 1'b0;
						for (int t = 0; t < MAX_TASKS; t++)
							cnt_q[t] <= '0;
					end else if (out_ready) begin
						emit_q <= emit_q + CW'(1);
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	logic [MAX_TASKS-1:0] row;
	assign row = adj_q[emit_q[TW-1:0]];
	assign out_valid = (state_q == ST_EMIT) && (emit_q < nout);

	always_comb begin
		out_data.task_index = OUT_IDX_W'(emit_q);
		out_data.dependency_mask = '0;
		for (int n = 0; n < OUT_TASKS; n++)
			if (n < MAX_TASKS)
				out_data.dependency_mask[n] = row[n];
		out_data.last = (emit_q + CW'(1) == nout);
		out_data.overflow = ovf_q;
	end

	`TDG_ASSERT(a_tcount_max, clk, arst_n, (tcount_q <= CW'(MAX_TASKS)), "task count overran")
	`TDG_ASSERT(a_no_in_busy, clk, arst_n, (!(in_ready && out_valid)), "load and emit overlap")
	`TDG_ASSERT_NEXT(a_emit_step, clk, arst_n, (out_valid && out_ready && !out_data.last),
		(out_valid), "emission gap")
endmodule
`default_nettype wire
